// ===== rtl/round_robin_context_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_CONTEXT_QUEUE_CORE_ASSERT_SVH
`define ROUND_ROBIN_CONTEXT_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check with reset masking
`define RRCQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds across reset
`define RRCQ_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRCQ_ASSERT(lbl, clk, rst, prop, msg)
`define RRCQ_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/rrcq_pkg.sv =====
// ----------------------------------------------------------------------------
// rrcq_pkg
// Shared types, constants and helpers of the round-robin context queue.
// ----------------------------------------------------------------------------
package rrcq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W       = 32;
  localparam int WORDS_W     = 16;

  localparam logic [1:0] OP_CREATE    = 2'd0;
  localparam logic [1:0] OP_START     = 2'd1;
  localparam logic [1:0] OP_SWITCH    = 2'd2;
  localparam logic [1:0] OP_TERMINATE = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [PTR_W-1:0]   saved;
    logic [PTR_W-1:0]   original;
    logic [WORDS_W-1:0] words;
  } entry_t;

  typedef struct packed {
    logic load;    // capture request
    logic read;    // read head and head+1 entries
    logic commit;  // update ring and results
  } cmd_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    ring_next = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

endpackage

// ===== rtl/rrcq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrcq_ctrl
// Request sequencer: idle, entry read, commit; drives busy and done.
// ----------------------------------------------------------------------------
`include "round_robin_context_queue_core_assert.svh"

module rrcq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output rrcq_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_READ;
      end
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
    end
  end

  assign busy       = (state != ST_IDLE);
  assign cmd.load   = start && (state == ST_IDLE);
  assign cmd.read   = (state == ST_READ);
  assign cmd.commit = (state == ST_EXEC);

  `RRCQ_ASSERT(a_done_after_exec, clk, rst, done |-> $past(state == ST_EXEC),
               "done without a commit cycle")
  `RRCQ_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> (busy && !done),
               "request accepted but sequencer not busy")
  `RRCQ_ASSERT_RST(a_reset_idle, clk, rst |=> (state == ST_IDLE && !done),
                   "sequencer not idle after reset")

endmodule

// ===== rtl/rrcq_datapath.sv =====
// ----------------------------------------------------------------------------
// rrcq_datapath
// Context ring memory, head/tail/count registers and result registers.
// ----------------------------------------------------------------------------
`include "round_robin_context_queue_core_assert.svh"

module rrcq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  rrcq_pkg::cmd_t               cmd,
  input  logic [1:0]                   opcode,
  input  logic [rrcq_pkg::PTR_W-1:0]   stack_pointer,
  input  logic [rrcq_pkg::WORDS_W-1:0] stack_words,
  output logic [1:0]                   status,
  output logic [rrcq_pkg::PTR_W-1:0]   next_pointer,
  output logic                         next_valid,
  output logic [rrcq_pkg::PTR_W-1:0]   freed_pointer,
  output logic [rrcq_pkg::WORDS_W-1:0] freed_words,
  output logic                         freed_valid
);

  rrcq_pkg::entry_t mem [rrcq_pkg::QUEUE_DEPTH];

  logic [1:0]                   req_op;
  logic [rrcq_pkg::PTR_W-1:0]   req_sp;
  logic [rrcq_pkg::WORDS_W-1:0] req_words;

  logic [rrcq_pkg::IDX_W-1:0] head;
  logic [rrcq_pkg::IDX_W-1:0] tail;
  logic [rrcq_pkg::CNT_W-1:0] count;
  logic [rrcq_pkg::IDX_W-1:0] head_next;
  logic [rrcq_pkg::IDX_W-1:0] tail_next;
  logic [rrcq_pkg::CNT_W-1:0] count_next;

  rrcq_pkg::entry_t rd_head;
  rrcq_pkg::entry_t rd_after;

  logic                         wr_en;
  rrcq_pkg::entry_t             wr_data;
  logic [1:0]                   status_next;
  logic [rrcq_pkg::PTR_W-1:0]   next_pointer_next;
  logic                         next_valid_next;
  logic [rrcq_pkg::PTR_W-1:0]   freed_pointer_next;
  logic [rrcq_pkg::WORDS_W-1:0] freed_words_next;
  logic                         freed_valid_next;
  logic [rrcq_pkg::IDX_W-1:0]   head_inc;
  logic [rrcq_pkg::IDX_W-1:0]   tail_inc;

  assign head_inc = rrcq_pkg::ring_next(head);
  assign tail_inc = rrcq_pkg::ring_next(tail);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= opcode;
      req_sp    <= stack_pointer;
      req_words <= stack_words;
    end
  end

  // registered reads of head and the entry after it
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_head  <= mem[head];
      rd_after <= mem[head_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[tail] <= wr_data;
    end
  end

  always_comb begin
    head_next          = head;
    tail_next          = tail;
    count_next         = count;
    wr_en              = 1'b0;
    wr_data            = '{saved: req_sp, original: req_sp, words: req_words};
    status_next        = rrcq_pkg::STAT_OK;
    next_pointer_next  = '0;
    next_valid_next    = 1'b0;
    freed_pointer_next = '0;
    freed_words_next   = '0;
    freed_valid_next   = 1'b0;
    if (req_op == rrcq_pkg::OP_CREATE) begin
      if (count == rrcq_pkg::CNT_W'(rrcq_pkg::QUEUE_DEPTH)) begin
        status_next = rrcq_pkg::STAT_FULL;
      end else begin
        wr_en      = 1'b1;
        tail_next  = tail_inc;
        count_next = count + rrcq_pkg::CNT_W'(1);
      end
    end else if (count == '0) begin
      status_next = rrcq_pkg::STAT_EMPTY;
    end else begin
      case (req_op)
        rrcq_pkg::OP_START: begin
          next_pointer_next = rd_head.saved;
          next_valid_next   = 1'b1;
        end
        rrcq_pkg::OP_SWITCH: begin
          wr_en     = 1'b1;
          wr_data   = '{saved: req_sp, original: rd_head.original, words: rd_head.words};
          head_next = head_inc;
          tail_next = tail_inc;
          // new head is the entry just written when only one process is queued
          next_pointer_next = (head_inc == tail) ? req_sp : rd_after.saved;
          next_valid_next   = 1'b1;
        end
        rrcq_pkg::OP_TERMINATE: begin
          freed_pointer_next = rd_head.original;
          freed_words_next   = rd_head.words;
          freed_valid_next   = 1'b1;
          head_next          = head_inc;
          count_next         = count - rrcq_pkg::CNT_W'(1);
          if (count == rrcq_pkg::CNT_W'(1)) begin
            status_next = rrcq_pkg::STAT_EMPTY;
          end else begin
            next_pointer_next = rd_after.saved;
            next_valid_next   = 1'b1;
          end
        end
        default: begin
          status_next = rrcq_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status        <= status_next;
      next_pointer  <= next_pointer_next;
      next_valid    <= next_valid_next;
      freed_pointer <= freed_pointer_next;
      freed_words   <= freed_words_next;
      freed_valid   <= freed_valid_next;
    end
  end

  `RRCQ_ASSERT(a_count_bound, clk, rst,
               count <= rrcq_pkg::CNT_W'(rrcq_pkg::QUEUE_DEPTH),
               "entry count above queue depth")
  `RRCQ_ASSERT(a_ends_meet, clk, rst,
               (count == '0 || count == rrcq_pkg::CNT_W'(rrcq_pkg::QUEUE_DEPTH))
               |-> (head == tail),
               "head and tail differ on empty or full ring")
  `RRCQ_ASSERT(a_ring_idle, clk, rst,
               !$past(cmd.commit) |-> ($stable(head) && $stable(tail) && $stable(count)),
               "ring pointers moved outside commit")

endmodule

// ===== rtl/round_robin_context_queue_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_context_queue_core
// Round-robin ready queue of process contexts kept in a 16-entry ring.
// Each request passes capture, ring read and commit; done is registered from
// the commit state, and a new request is taken only while the sequencer is idle.
// busy is low again in the cycle that shows done; results cannot be stalled.
// Synchronous reset empties the queue; ring contents are not cleared.
// ----------------------------------------------------------------------------
module round_robin_context_queue_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode,
  input  logic [rrcq_pkg::PTR_W-1:0]   stack_pointer,
  input  logic [rrcq_pkg::WORDS_W-1:0] stack_words,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [rrcq_pkg::PTR_W-1:0]   next_pointer,
  output logic                         next_valid,
  output logic [rrcq_pkg::PTR_W-1:0]   freed_pointer,
  output logic [rrcq_pkg::WORDS_W-1:0] freed_words,
  output logic                         freed_valid
);

  rrcq_pkg::cmd_t cmd;

  rrcq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  rrcq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .opcode        (opcode),
    .stack_pointer (stack_pointer),
    .stack_words   (stack_words),
    .status        (status),
    .next_pointer  (next_pointer),
    .next_valid    (next_valid),
    .freed_pointer (freed_pointer),
    .freed_words   (freed_words),
    .freed_valid   (freed_valid)
  );

endmodule
